@@ design/okq_pkg.sv @@
package okq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_BYTES   = 20;
   localparam int KEY_W       = 8 * KEY_BYTES;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Action codes.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_FIND   = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Returned in the low word when removing from an empty queue (the string "0").
   localparam logic [63:0] EMPTY_MARK = 64'h30;

   // Commands broadcast to every cell of the chain.
   typedef logic [2:0] cell_cmd_type;
   localparam cell_cmd_type CMD_HOLD   = 3'd0;
   localparam cell_cmd_type CMD_MATCH  = 3'd1;
   localparam cell_cmd_type CMD_SWEEP  = 3'd2;
   localparam cell_cmd_type CMD_INSERT = 3'd3;
   localparam cell_cmd_type CMD_REMOVE = 3'd4;
   localparam cell_cmd_type CMD_DELETE = 3'd5;

   typedef struct packed {
      cell_cmd_type           cmd;
      logic                   found;
      logic [CNT_W-1:0]       occ;
      logic [KEY_W-1:0]       key;
   } cell_ctrl_type;

   // Clear every byte after the first zero byte of the key.
   function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw);
      logic [KEY_BYTES-1:0] zero_byte;
      logic [KEY_BYTES-1:0] lower_mask;
      logic [KEY_W-1:0]     result;
      for (int i = 0; i < KEY_BYTES; i++) begin
         zero_byte[i] = (raw[8*i +: 8] == 8'd0);
      end
      for (int i = 0; i < KEY_BYTES; i++) begin
         lower_mask = (KEY_BYTES'(1) << i) - KEY_BYTES'(1);
         result[8*i +: 8] = ((zero_byte & lower_mask) == '0) ? raw[8*i +: 8] : 8'd0;
      end
      return result;
   endfunction

endpackage

@@ design/okq_req_if.sv @@
interface okq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] key_word0;
   logic [63:0] key_word1;
   logic [31:0] key_word2;

   modport source (output valid, action, key_word0, key_word1, key_word2, input ready);
   modport sink   (input valid, action, key_word0, key_word1, key_word2, output ready);
endinterface

@@ design/okq_rsp_if.sv @@
interface okq_rsp_if import okq_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [63:0]      out_word0;
   logic [63:0]      out_word1;
   logic [31:0]      out_word2;
   logic [CNT_W-1:0] fill_count;

   modport source (output valid, status, out_word0, out_word1, out_word2, fill_count,
                   input ready);
   modport sink   (input valid, status, out_word0, out_word1, out_word2, fill_count,
                   output ready);
endinterface

@@ design/okq_cell.sv @@
module okq_cell
   import okq_pkg::*;
(
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [IDX_W-1:0] idx,
   input  logic [KEY_W-1:0] nbr_key,
   input  logic             nbr_match,
   input  logic             nbr_above,
   output logic [KEY_W-1:0] key,
   output logic             match,
   output logic             above
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             match_ff, match_in;
   logic             above_ff, above_in;
   logic             occupied;

   // The cell holds a live entry when its place is below the fill count.
   assign occupied = (CNT_W'(idx) < ctrl.occ);

   always_comb begin
      key_in   = key_ff;
      match_in = match_ff;
      above_in = above_ff;
      unique case (ctrl.cmd)
         CMD_MATCH: begin
            match_in = occupied && (key_ff == ctrl.key);
            above_in = 1'b0;
         end
         // A match somewhere above travels one cell down per cycle.
         CMD_SWEEP: begin
            above_in = nbr_match | nbr_above;
         end
         CMD_INSERT: begin
            if (CNT_W'(idx) == ctrl.occ) begin
               key_in = ctrl.key;
            end
         end
         CMD_REMOVE: begin
            key_in = nbr_key;
         end
         // Cells at and above the newest match take the key of the next cell.
         CMD_DELETE: begin
            if (ctrl.found && !above_ff) begin
               key_in = nbr_key;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
      above_ff <= above_in;
   end

   assign key   = key_ff;
   assign match = match_ff;
   assign above = above_ff;

endmodule

@@ design/ordered_key_queue_with_remove_unit.sv @@
// Ordered key queue with remove.
//
// The req channel carries one action per item: insert a 20-byte key as the
// newest entry, remove the oldest entry, or find the newest entry equal to
// the key and delete it. The rsp channel returns one item per action with a
// status, the removed key (zero otherwise, the string "0" when removing from
// an empty queue) and the fill count after the action.
// Insert, remove and the unused action code go from acceptance straight to the
// done step, which writes the result register. Find and delete goes through
// compare, sweep and done steps: every cell compares its key, then the newest
// match ripples down the chain of cells one cell per cycle, and the entries
// close the gap in the cycle that writes the result. One item is worked on at
// a time; a new item is accepted as soon as the previous one has been written
// to the result register, even while that result waits for the receiver.
// When the receiver stalls, a finished item waits before updating the queue
// until the result register is free.
// Reset empties the queue and drops any pending result; no clearing pass.
module ordered_key_queue_with_remove_unit
   import okq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   okq_req_if.sink    req_ch,
   okq_rsp_if.source  rsp_ch
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_COMP  = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [1:0]       action_ff, action_in;
   logic [KEY_W-1:0] key_ff, key_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic [63:0]      word0_ff, word0_in;
   logic [63:0]      word1_ff, word1_in;
   logic [31:0]      word2_ff, word2_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   logic             req_fire;
   logic             done_fire;
   logic             found;
   cell_ctrl_type    ctrl;

   logic [KEY_W-1:0] cell_key   [QUEUE_DEPTH];
   logic             cell_match [QUEUE_DEPTH];
   logic             cell_above [QUEUE_DEPTH];
   logic [KEY_W-1:0] nbr_key    [QUEUE_DEPTH];
   logic             nbr_match  [QUEUE_DEPTH];
   logic             nbr_above  [QUEUE_DEPTH];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign done_fire    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign found        = cell_match[0] | cell_above[0];

   // Sequencer: find goes through compare and sweep, other actions go straight to done.
   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               action_in = req_ch.action;
               key_in    = canon_key({req_ch.key_word2, req_ch.key_word1, req_ch.key_word0});
               state_in  = (req_ch.action == ACT_FIND) ? S_COMP : S_DONE;
            end
         end
         S_COMP: begin
            sweep_cnt_in = '0;
            state_in     = S_SWEEP;
         end
         S_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + IDX_W'(1);
            if (sweep_cnt_ff == IDX_W'(QUEUE_DEPTH - 2)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Command to the cells and the result of the action.
   always_comb begin
      ctrl.cmd     = CMD_HOLD;
      ctrl.found   = found;
      ctrl.occ     = occ_ff;
      ctrl.key     = key_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      word0_in     = word0_ff;
      word1_in     = word1_ff;
      word2_in     = word2_ff;
      fill_in      = fill_ff;
      if (state_ff == S_COMP) begin
         ctrl.cmd = CMD_MATCH;
      end else if (state_ff == S_SWEEP) begin
         ctrl.cmd = CMD_SWEEP;
      end else if (done_fire) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         word0_in     = '0;
         word1_in     = '0;
         word2_in     = '0;
         unique case (action_ff)
            ACT_INSERT: begin
               if (occ_ff == CNT_W'(QUEUE_DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.cmd = CMD_INSERT;
                  occ_in   = occ_ff + CNT_W'(1);
               end
            end
            ACT_REMOVE: begin
               if (occ_ff == '0) begin
                  status_in = ST_EMPTY;
                  word0_in  = EMPTY_MARK;
               end else begin
                  ctrl.cmd = CMD_REMOVE;
                  occ_in   = occ_ff - CNT_W'(1);
                  word0_in = cell_key[0][63:0];
                  word1_in = cell_key[0][127:64];
                  word2_in = cell_key[0][159:128];
               end
            end
            ACT_FIND: begin
               if (occ_ff == '0) begin
                  status_in = ST_EMPTY;
               end else if (found) begin
                  ctrl.cmd = CMD_DELETE;
                  occ_in   = occ_ff - CNT_W'(1);
               end else begin
                  status_in = ST_NOTFOUND;
               end
            end
            default: begin
            end
         endcase
         fill_in = occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sweep_cnt_ff <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      word0_ff  <= word0_in;
      word1_ff  <= word1_in;
      word2_ff  <= word2_in;
      fill_ff   <= fill_in;
   end

   // Chain of cells; entry 0 is the oldest, each cell sees the next newer one.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i < QUEUE_DEPTH - 1) begin : g_link
         assign nbr_key[i]   = cell_key[i+1];
         assign nbr_match[i] = cell_match[i+1];
         assign nbr_above[i] = cell_above[i+1];
      end else begin : g_end
         assign nbr_key[i]   = '0;
         assign nbr_match[i] = 1'b0;
         assign nbr_above[i] = 1'b0;
      end
      okq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .idx       (IDX_W'(i)),
         .nbr_key   (nbr_key[i]),
         .nbr_match (nbr_match[i]),
         .nbr_above (nbr_above[i]),
         .key       (cell_key[i]),
         .match     (cell_match[i]),
         .above     (cell_above[i])
      );
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.out_word0  = word0_ff;
   assign rsp_ch.out_word1  = word1_ff;
   assign rsp_ch.out_word2  = word2_ff;
   assign rsp_ch.fill_count = fill_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      done_fire && (action_ff == ACT_INSERT) && (occ_ff != CNT_W'(QUEUE_DEPTH))
      |=> occ_ff == $past(occ_ff) + CNT_W'(1))
      else $error("insert did not grow the queue");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_FULL) |-> rsp_ch.fill_count == CNT_W'(QUEUE_DEPTH))
      else $error("full status with room left");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_EMPTY) |-> rsp_ch.fill_count == '0)
      else $error("empty status with entries held");

   a_queue_stable_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(occ_ff))
      else $error("fill count changed outside the update step");
`endif

endmodule
